// ----- rtl/core/qwse_pkg.sv -----
// Shared types, constants and the per-node operand table of the wedge
// shape-function evaluator. Used by every module of the block; depends on nothing.
`default_nettype none

package qwse_pkg;

   localparam int COORD_W       = 16;
   localparam int NODE_W        = 4;
   localparam int RES_W         = 32;
   localparam int NUM_NODES     = 15;
   localparam int FRAC_BITS_DEF = 13;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_DATA_W    = 3 * COORD_W;
   localparam int RSP_FIELDS_W  = NODE_W + 4 * RES_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NUM_NODES - 1);

   // Linear terms of the point, worked out once per item by the front end.
   typedef enum logic [4:0] {
      T_R, T_S, T_T, T_U, T_B,
      T_W0, T_W1, T_W2, T_W3, T_W4, T_W5,
      T_RA, T_RB, T_RC, T_RD, T_RE,
      T_SB, T_SD, T_SE,
      T_TA, T_TB, T_TC, T_TD, T_TE, T_TF, T_TG
   } qwse_term_type;

   localparam int NUM_TERMS = 26;

   // Constant factor applied to a product before rounding.
   typedef enum logic [1:0] {
      SC_ZERO, SC_P2, SC_P4, SC_N4
   } qwse_scale_type;

   typedef struct packed {
      qwse_term_type  w_a;
      qwse_term_type  w_b;
      qwse_term_type  w_c;
      qwse_scale_type w_sc;
      qwse_term_type  dr_a;
      qwse_term_type  dr_b;
      qwse_scale_type dr_sc;
      qwse_term_type  ds_a;
      qwse_term_type  ds_b;
      qwse_scale_type ds_sc;
      qwse_term_type  dt_a;
      qwse_term_type  dt_b;
      qwse_scale_type dt_sc;
   } qwse_sel_type;

   // Width of a linear term: room for the coordinates or the unit value,
   // plus headroom for sums of up to five scaled coordinates.
   function automatic int qwse_term_w(input int frac);
      int base;
      base = (frac + 1 > COORD_W) ? frac + 1 : COORD_W;
      return base + 4;
   endfunction

   function automatic int qwse_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic qwse_sel_type qwse_ent(
      input qwse_term_type wa, input qwse_term_type wb, input qwse_term_type wc,
      input qwse_scale_type wsc,
      input qwse_term_type ra, input qwse_term_type rb, input qwse_scale_type rsc,
      input qwse_term_type sa, input qwse_term_type sb, input qwse_scale_type ssc,
      input qwse_term_type ta, input qwse_term_type tb, input qwse_scale_type tsc);
      qwse_sel_type e;
      e.w_a  = wa;  e.w_b  = wb;  e.w_c = wc; e.w_sc = wsc;
      e.dr_a = ra;  e.dr_b = rb;  e.dr_sc = rsc;
      e.ds_a = sa;  e.ds_b = sb;  e.ds_sc = ssc;
      e.dt_a = ta;  e.dt_b = tb;  e.dt_sc = tsc;
      return e;
   endfunction

   // Weight = scale * a * b * c, each derivative = scale * a * b.
   function automatic qwse_sel_type qwse_node_sel(input logic [NODE_W-1:0] node);
      qwse_sel_type e;
      unique case (node)
         4'd0:  e = qwse_ent(T_U, T_B, T_W0, SC_P2, T_B, T_RA, SC_P2,
                            T_B, T_RA, SC_P2, T_U, T_TA, SC_P2);
         4'd1:  e = qwse_ent(T_R, T_B, T_W1, SC_P2, T_B, T_RB, SC_P2,
                            T_R, T_R, SC_ZERO, T_R, T_TB, SC_P2);
         4'd2:  e = qwse_ent(T_S, T_B, T_W2, SC_P2, T_R, T_R, SC_ZERO,
                            T_B, T_SB, SC_P2, T_S, T_TC, SC_P2);
         4'd3:  e = qwse_ent(T_U, T_T, T_W3, SC_P2, T_T, T_RC, SC_P2,
                            T_T, T_RC, SC_P2, T_U, T_TD, SC_P2);
         4'd4:  e = qwse_ent(T_R, T_T, T_W4, SC_P2, T_T, T_RD, SC_P2,
                            T_R, T_R, SC_ZERO, T_R, T_TE, SC_P2);
         4'd5:  e = qwse_ent(T_S, T_T, T_W5, SC_P2, T_R, T_R, SC_ZERO,
                            T_T, T_SD, SC_P2, T_S, T_TF, SC_P2);
         4'd6:  e = qwse_ent(T_R, T_U, T_B, SC_P4, T_B, T_RE, SC_P4,
                            T_B, T_R, SC_N4, T_R, T_U, SC_N4);
         4'd7:  e = qwse_ent(T_R, T_S, T_B, SC_P4, T_B, T_S, SC_P4,
                            T_B, T_R, SC_P4, T_R, T_S, SC_N4);
         4'd8:  e = qwse_ent(T_U, T_S, T_B, SC_P4, T_B, T_S, SC_N4,
                            T_B, T_SE, SC_P4, T_S, T_U, SC_N4);
         4'd9:  e = qwse_ent(T_R, T_U, T_T, SC_P4, T_T, T_RE, SC_P4,
                            T_R, T_T, SC_N4, T_R, T_U, SC_P4);
         4'd10: e = qwse_ent(T_R, T_S, T_T, SC_P4, T_S, T_T, SC_P4,
                            T_R, T_T, SC_P4, T_R, T_S, SC_P4);
         4'd11: e = qwse_ent(T_U, T_S, T_T, SC_P4, T_S, T_T, SC_N4,
                            T_T, T_SE, SC_P4, T_S, T_U, SC_P4);
         4'd12: e = qwse_ent(T_T, T_U, T_B, SC_P4, T_T, T_B, SC_N4,
                            T_T, T_B, SC_N4, T_TG, T_U, SC_P4);
         4'd13: e = qwse_ent(T_T, T_R, T_B, SC_P4, T_T, T_B, SC_P4,
                            T_R, T_R, SC_ZERO, T_TG, T_R, SC_P4);
         4'd14: e = qwse_ent(T_T, T_S, T_B, SC_P4, T_R, T_R, SC_ZERO,
                            T_T, T_B, SC_P4, T_TG, T_S, SC_P4);
         default: e = qwse_ent(T_R, T_R, T_R, SC_ZERO, T_R, T_R, SC_ZERO,
                               T_R, T_R, SC_ZERO, T_R, T_R, SC_ZERO);
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qwse_front.sv -----
// Front end: takes in a point and works out all linear terms of r, s and t
// that the node polynomials need. Depends on qwse_pkg.
`default_nettype none

module qwse_front
   import qwse_pkg::*;
#(
   parameter  int FRAC_BITS = FRAC_BITS_DEF,
   localparam int TW        = qwse_term_w(FRAC_BITS)
) (
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [REQ_DATA_W-1:0]            in_data,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic [NUM_TERMS-1:0][TW-1:0]     terms
);

   localparam logic signed [TW-1:0] One   = TW'(64'd1 << FRAC_BITS);
   localparam logic signed [TW-1:0] Half  = TW'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [TW-1:0] ThHlf = TW'(64'd3 << (FRAC_BITS - 1));

   logic signed [TW-1:0] r, s, t;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;

   always_comb begin
      r = TW'(signed'(in_data[COORD_W-1:0]));
      s = TW'(signed'(in_data[2*COORD_W-1:COORD_W]));
      t = TW'(signed'(in_data[3*COORD_W-1:2*COORD_W]));

      terms       = '0;
      terms[T_R]  = r;
      terms[T_S]  = s;
      terms[T_T]  = t;
      terms[T_U]  = One - r - s;
      terms[T_B]  = One - t;
      terms[T_W0] = Half - r - s - t;
      terms[T_W1] = r - t - Half;
      terms[T_W2] = s - t - Half;
      terms[T_W3] = t - r - s - Half;
      terms[T_W4] = r + t - ThHlf;
      terms[T_W5] = s + t - ThHlf;
      terms[T_RA] = (r <<< 1) + (s <<< 1) + t - ThHlf;
      terms[T_RB] = (r <<< 1) - t - Half;
      terms[T_RC] = (r <<< 1) + (s <<< 1) - t - Half;
      terms[T_RD] = (r <<< 1) + t - ThHlf;
      terms[T_RE] = One - (r <<< 1) - s;
      terms[T_SB] = (s <<< 1) - t - Half;
      terms[T_SD] = (s <<< 1) + t - ThHlf;
      terms[T_SE] = One - r - (s <<< 1);
      terms[T_TA] = r + s + (t <<< 1) - ThHlf;
      terms[T_TB] = (t <<< 1) - r - Half;
      terms[T_TC] = (t <<< 1) - s - Half;
      terms[T_TD] = (t <<< 1) - r - s - Half;
      terms[T_TE] = r + (t <<< 1) - ThHlf;
      terms[T_TF] = s + (t <<< 1) - ThHlf;
      terms[T_TG] = One - (t <<< 1);
   end

endmodule

`default_nettype wire

// ----- rtl/core/qwse_queue.sv -----
// Short first-in first-out queue of term sets between front and back end.
// Depends on qwse_pkg for its depth.
`default_nettype none

module qwse_queue
   import qwse_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/qwse_back.sv -----
// Back end: walks the fifteen nodes of the queue head item, one a cycle while
// unstalled, via a four-stage multiply and round pipeline. Depends on qwse_pkg.
`default_nettype none

module qwse_back
   import qwse_pkg::*;
#(
   parameter  int FRAC_BITS = FRAC_BITS_DEF,
   localparam int TW        = qwse_term_w(FRAC_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   output logic                          head_pop,
   input  logic [NUM_TERMS-1:0][TW-1:0]  head_terms,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NODE_W-1:0]             out_node,
   output logic signed [RES_W-1:0]       out_weight,
   output logic signed [RES_W-1:0]       out_d_dr,
   output logic signed [RES_W-1:0]       out_d_ds,
   output logic signed [RES_W-1:0]       out_d_dt,
   output logic                          out_last
);

   localparam int DSumW = qwse_max(2 * TW + 4, 2 * FRAC_BITS + RES_W);
   localparam int WSumW = qwse_max(3 * TW + 4, 3 * FRAC_BITS + RES_W);
   localparam logic signed [DSumW-1:0] DHalf = DSumW'(1) <<< (2 * FRAC_BITS - 1);
   localparam logic signed [WSumW-1:0] WHalf = WSumW'(1) <<< (3 * FRAC_BITS - 1);

   // Scale, then round half up at the given fraction point; low 32 bits kept.
   function automatic logic signed [RES_W-1:0] d_round(
      input logic signed [2*TW-1:0] p, input qwse_scale_type sc);
      logic signed [DSumW-1:0] ext, scaled, sum;
      ext = DSumW'(p);
      unique case (sc)
         SC_ZERO: scaled = '0;
         SC_P2:   scaled = ext <<< 1;
         SC_P4:   scaled = ext <<< 2;
         SC_N4:   scaled = -(ext <<< 2);
      endcase
      sum = scaled + DHalf;
      return sum[2*FRAC_BITS+RES_W-1:2*FRAC_BITS];
   endfunction

   function automatic logic signed [RES_W-1:0] w_round(
      input logic signed [3*TW-1:0] p, input qwse_scale_type sc);
      logic signed [WSumW-1:0] ext, scaled, sum;
      ext = WSumW'(p);
      unique case (sc)
         SC_ZERO: scaled = '0;
         SC_P2:   scaled = ext <<< 1;
         SC_P4:   scaled = ext <<< 2;
         SC_N4:   scaled = -(ext <<< 2);
      endcase
      sum = scaled + WHalf;
      return sum[3*FRAC_BITS+RES_W-1:3*FRAC_BITS];
   endfunction

   logic                advance, issue;
   logic [NODE_W-1:0]   node_ff, node_in;
   qwse_sel_type        sel;

   // Stage 1: selected operands.
   logic                v1_ff, v1_in;
   logic signed [TW-1:0] wa1_ff, wb1_ff, wc1_ff, dra1_ff, drb1_ff;
   logic signed [TW-1:0] dsa1_ff, dsb1_ff, dta1_ff, dtb1_ff;
   logic signed [TW-1:0] wa1_in, wb1_in, wc1_in, dra1_in, drb1_in;
   logic signed [TW-1:0] dsa1_in, dsb1_in, dta1_in, dtb1_in;
   qwse_scale_type      wsc1_ff, drsc1_ff, dssc1_ff, dtsc1_ff;
   logic [NODE_W-1:0]   node1_ff;
   logic                last1_ff;

   // Stage 2: first products.
   logic                    v2_ff;
   logic signed [2*TW-1:0]  pw2_ff, pdr2_ff, pds2_ff, pdt2_ff;
   logic signed [2*TW-1:0]  pw2_in, pdr2_in, pds2_in, pdt2_in;
   logic signed [TW-1:0]    wc2_ff;
   qwse_scale_type          wsc2_ff, drsc2_ff, dssc2_ff, dtsc2_ff;
   logic [NODE_W-1:0]       node2_ff;
   logic                    last2_ff;

   // Stage 3: weight product, rounded derivatives.
   logic                    v3_ff;
   logic signed [3*TW-1:0]  pw3_ff, pw3_in;
   logic signed [RES_W-1:0] dr3_ff, ds3_ff, dt3_ff, dr3_in, ds3_in, dt3_in;
   qwse_scale_type          wsc3_ff;
   logic [NODE_W-1:0]       node3_ff;
   logic                    last3_ff;

   // Stage 4: output register.
   logic                    v4_ff;
   logic signed [RES_W-1:0] w4_ff, w4_in, dr4_ff, ds4_ff, dt4_ff;
   logic [NODE_W-1:0]       node4_ff;
   logic                    last4_ff;

   assign advance  = !v4_ff || out_ready;
   assign issue    = advance && head_valid;
   assign head_pop = issue && (node_ff == LAST_NODE);
   assign sel      = qwse_node_sel(node_ff);

   always_comb begin
      node_in = node_ff;
      if (issue) begin
         node_in = (node_ff == LAST_NODE) ? '0 : node_ff + NODE_W'(1);
      end
      v1_in   = head_valid;
      wa1_in  = signed'(head_terms[sel.w_a]);
      wb1_in  = signed'(head_terms[sel.w_b]);
      wc1_in  = signed'(head_terms[sel.w_c]);
      dra1_in = signed'(head_terms[sel.dr_a]);
      drb1_in = signed'(head_terms[sel.dr_b]);
      dsa1_in = signed'(head_terms[sel.ds_a]);
      dsb1_in = signed'(head_terms[sel.ds_b]);
      dta1_in = signed'(head_terms[sel.dt_a]);
      dtb1_in = signed'(head_terms[sel.dt_b]);
      pw2_in  = wa1_ff * wb1_ff;
      pdr2_in = dra1_ff * drb1_ff;
      pds2_in = dsa1_ff * dsb1_ff;
      pdt2_in = dta1_ff * dtb1_ff;
      pw3_in  = pw2_ff * wc2_ff;
      dr3_in  = d_round(pdr2_ff, drsc2_ff);
      ds3_in  = d_round(pds2_ff, dssc2_ff);
      dt3_in  = d_round(pdt2_ff, dtsc2_ff);
      w4_in   = w_round(pw3_ff, wsc3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         node_ff <= node_in;
         if (advance) begin
            v1_ff <= v1_in;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wa1_ff   <= wa1_in;
         wb1_ff   <= wb1_in;
         wc1_ff   <= wc1_in;
         dra1_ff  <= dra1_in;
         drb1_ff  <= drb1_in;
         dsa1_ff  <= dsa1_in;
         dsb1_ff  <= dsb1_in;
         dta1_ff  <= dta1_in;
         dtb1_ff  <= dtb1_in;
         wsc1_ff  <= sel.w_sc;
         drsc1_ff <= sel.dr_sc;
         dssc1_ff <= sel.ds_sc;
         dtsc1_ff <= sel.dt_sc;
         node1_ff <= node_ff;
         last1_ff <= (node_ff == LAST_NODE);

         pw2_ff   <= pw2_in;
         pdr2_ff  <= pdr2_in;
         pds2_ff  <= pds2_in;
         pdt2_ff  <= pdt2_in;
         wc2_ff   <= wc1_ff;
         wsc2_ff  <= wsc1_ff;
         drsc2_ff <= drsc1_ff;
         dssc2_ff <= dssc1_ff;
         dtsc2_ff <= dtsc1_ff;
         node2_ff <= node1_ff;
         last2_ff <= last1_ff;

         pw3_ff   <= pw3_in;
         dr3_ff   <= dr3_in;
         ds3_ff   <= ds3_in;
         dt3_ff   <= dt3_in;
         wsc3_ff  <= wsc2_ff;
         node3_ff <= node2_ff;
         last3_ff <= last2_ff;

         w4_ff    <= w4_in;
         dr4_ff   <= dr3_ff;
         ds4_ff   <= ds3_ff;
         dt4_ff   <= dt3_ff;
         node4_ff <= node3_ff;
         last4_ff <= last3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_node   = node4_ff;
   assign out_weight = w4_ff;
   assign out_d_dr   = dr4_ff;
   assign out_d_ds   = ds4_ff;
   assign out_d_dt   = dt4_ff;
   assign out_last   = last4_ff;

endmodule

`default_nettype wire

// ----- rtl/core/quadratic_wedge_shape_eval.sv -----
// An accepted item yields one result per node, from node 0 to node 14 in
// order; one result leaves every cycle unless the output stalls.
// Items are evaluated by the single back-end pipeline, one node per cycle
// while not stalled. The queue holds two items.
// Reset: synchronous, active high; clears valid bits, queue pointers and the
// node counter. There is no clearing pass, the block is ready straight away.
`default_nettype none

module quadratic_wedge_shape_eval
   import qwse_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] r_coord, [31:16] s_coord, [47:32] t_coord
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] node_index, [35:4] weight, [67:36] d_dr, [99:68] d_ds,
   // [131:100] d_dt, [135:132] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int TW    = qwse_term_w(FRAC_BITS);
   localparam int QW    = NUM_TERMS * TW;

   // The front end turns a point into its set of linear terms in the cycle
   // it is accepted; the set is written straight into the queue, so an item
   // is accepted whenever the queue has room, independent of the back end.
   logic                          push_valid, push_ready;
   logic [NUM_TERMS-1:0][TW-1:0]  front_terms, head_terms;
   logic                          head_valid, head_pop;
   logic [QW-1:0]                 head_bits;

   logic [NODE_W-1:0]             rsp_node;
   logic signed [RES_W-1:0]       rsp_weight, rsp_d_dr, rsp_d_ds, rsp_d_dt;

   qwse_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .terms      (front_terms)
   );

   qwse_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (front_terms),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_data   (head_bits)
   );

   assign head_terms = head_bits;

   // The back end holds the queue head while stepping its node counter over all
   // fifteen nodes, and releases the entry as node 14 enters the pipeline. The
   // whole pipeline stalls together when the output register is full and
   // not being taken, so a result never moves while it is on offer.
   qwse_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_terms (head_terms),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_node   (rsp_node),
      .out_weight (rsp_weight),
      .out_d_dr   (rsp_d_dr),
      .out_d_ds   (rsp_d_ds),
      .out_d_dt   (rsp_d_dt),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                       rsp_d_dt, rsp_d_ds, rsp_d_dr, rsp_weight, rsp_node};

   // The end-of-run mark sits on node 14 and on no other node.
   a_last_on_final_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_node == LAST_NODE)))
      else $error("end-of-run mark does not match node 14");

   // Within a run the nodes leave back to back and in order.
   a_run_in_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && (rsp_node == $past(rsp_node) + NODE_W'(1))))
      else $error("node results of one run not contiguous or out of order");

   // Nothing is offered straight after a reset.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

`default_nettype wire
